// ----- rtl/imu_fp_pkg.sv -----
`timescale 1ns / 1ps
package imu_fp_pkg;

  typedef enum logic [3:0] {
    PH_IDLE, PH_B1, PH_B2, PH_LENL, PH_LENH, PH_CRCL, PH_CRCH, PH_PAY, PH_DONE, PH_BAD
  } phase_t;

  localparam logic [7:0]  SYNC_A      = 8'h5A;
  localparam logic [7:0]  SYNC_B      = 8'hA5;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [7:0]  ID_SKIP     = 8'h90;
  localparam logic [7:0]  ID_ACCEL    = 8'hA0;
  localparam logic [7:0]  ID_RATE     = 8'hB0;
  localparam logic [7:0]  ID_MAGNET   = 8'hC0;
  localparam logic [7:0]  ID_ATTITUDE = 8'hD0;
  localparam logic [7:0]  ID_NONE     = 8'h00;
  localparam logic [3:0]  ALL_SEEN    = 4'hF;
  localparam logic [16:0] ANGLE_BIAS  = 17'd1800;
  localparam logic [16:0] YAW_BASE    = 17'd3600;
  localparam logic [33:0] DIV10_MUL   = 34'd52429;
  localparam int          DIV10_SHIFT = 19;
  localparam logic [2:0]  REC_BYTES   = 3'd6;

  localparam logic [1:0] RUN_PARSING = 2'd0;
  localparam logic [1:0] RUN_ALLSEEN = 2'd1;
  localparam logic [1:0] RUN_UNKNOWN = 2'd2;

  localparam logic [2:0] KIND_STATUS = 3'd4;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NO_FRAME   = 3'd1;
  localparam logic [2:0] ST_CRC_BAD    = 3'd2;
  localparam logic [2:0] ST_INCOMPLETE = 3'd3;
  localparam logic [2:0] ST_UNKNOWN_ID = 3'd4;

  typedef struct packed {
    logic [3:0]             mask;
    logic [2:0]             status;
    logic [3:0][2:0][16:0]  hold;
  } frame_result_t;

  function automatic logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    end
    return r;
  endfunction

  // truncating divide by ten, then bias
  function automatic logic [16:0] angle_conv(logic [15:0] v);
    logic [16:0] mag;
    logic [33:0] prod;
    logic [16:0] q;
    mag  = v[15] ? (17'd0 - {v[15], v}) : {1'b0, v};
    prod = 34'(mag) * DIV10_MUL;
    q    = 17'(prod >> DIV10_SHIFT);
    return (v[15] ? (17'd0 - q) : q) + ANGLE_BIAS;
  endfunction

endpackage

// ----- rtl/imu_fp_parse.sv -----
`timescale 1ns / 1ps
module imu_fp_parse (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         take,
  input  logic [7:0]                   data_byte,
  input  logic                         burst_start,
  input  logic                         burst_end,
  output logic                         res_valid,
  output imu_fp_pkg::frame_result_t    res
);

  imu_fp_pkg::phase_t phase, phase_next;
  logic [15:0] byte_counter, byte_counter_next;
  logic [15:0] payload_length, payload_length_next;
  logic [15:0] crc_accum, crc_accum_next;
  logic [15:0] crc_received, crc_received_next;
  logic [47:0] record_stage, record_stage_next;
  logic [7:0]  record_code, record_code_next;
  logic [2:0]  record_offset, record_offset_next;
  logic [3:0]  seen_mask, seen_mask_next;
  logic [1:0]  parse_stopped, parse_stopped_next;
  logic [3:0][2:0][16:0] hold, hold_next;

  always_comb begin
    logic active;
    logic [1:0] kind;
    phase_next          = phase;
    byte_counter_next   = byte_counter;
    payload_length_next = payload_length;
    crc_accum_next      = crc_accum;
    crc_received_next   = crc_received;
    record_stage_next   = record_stage;
    record_code_next    = record_code;
    record_offset_next  = record_offset;
    seen_mask_next      = seen_mask;
    parse_stopped_next  = parse_stopped;
    hold_next           = hold;
    res_valid           = 1'b0;
    res                 = '0;
    active              = 1'b0;
    kind                = 2'd0;
    if (take) begin
      if (burst_start) begin
        active              = 1'b1;
        byte_counter_next   = '0;
        payload_length_next = '0;
        crc_received_next   = '0;
        record_stage_next   = '0;
        record_code_next    = imu_fp_pkg::ID_NONE;
        record_offset_next  = '0;
        seen_mask_next      = '0;
        parse_stopped_next  = imu_fp_pkg::RUN_PARSING;
        if (data_byte == imu_fp_pkg::SYNC_A) begin
          crc_accum_next = imu_fp_pkg::crc_byte(16'h0000, data_byte);
          phase_next     = imu_fp_pkg::PH_B1;
        end else begin
          crc_accum_next = '0;
          phase_next     = imu_fp_pkg::PH_BAD;
        end
      end else if (phase != imu_fp_pkg::PH_IDLE) begin
        active = 1'b1;
        case (phase)
          imu_fp_pkg::PH_B1: begin
            if (data_byte == imu_fp_pkg::SYNC_B) begin
              crc_accum_next = imu_fp_pkg::crc_byte(crc_accum, data_byte);
              phase_next     = imu_fp_pkg::PH_LENL;
            end else if (data_byte == imu_fp_pkg::SYNC_A) begin
              phase_next = imu_fp_pkg::PH_B2;
            end else begin
              phase_next = imu_fp_pkg::PH_BAD;
            end
          end
          imu_fp_pkg::PH_B2: begin
            if (data_byte == imu_fp_pkg::SYNC_B) begin
              crc_accum_next = imu_fp_pkg::crc_byte(crc_accum, data_byte);
              phase_next     = imu_fp_pkg::PH_LENL;
            end else begin
              phase_next = imu_fp_pkg::PH_BAD;
            end
          end
          imu_fp_pkg::PH_LENL: begin
            crc_accum_next      = imu_fp_pkg::crc_byte(crc_accum, data_byte);
            payload_length_next = {8'h00, data_byte};
            phase_next          = imu_fp_pkg::PH_LENH;
          end
          imu_fp_pkg::PH_LENH: begin
            crc_accum_next      = imu_fp_pkg::crc_byte(crc_accum, data_byte);
            payload_length_next = {data_byte, payload_length[7:0]};
            phase_next          = imu_fp_pkg::PH_CRCL;
          end
          imu_fp_pkg::PH_CRCL: begin
            crc_received_next = {8'h00, data_byte};
            phase_next        = imu_fp_pkg::PH_CRCH;
          end
          imu_fp_pkg::PH_CRCH: begin
            crc_received_next = {data_byte, crc_received[7:0]};
            phase_next = (payload_length == 16'd0) ? imu_fp_pkg::PH_DONE
                                                   : imu_fp_pkg::PH_PAY;
          end
          imu_fp_pkg::PH_PAY: begin
            crc_accum_next    = imu_fp_pkg::crc_byte(crc_accum, data_byte);
            byte_counter_next = byte_counter + 16'd1;
            if (byte_counter_next >= payload_length) phase_next = imu_fp_pkg::PH_DONE;
            if (parse_stopped == imu_fp_pkg::RUN_PARSING) begin
              if (record_code == imu_fp_pkg::ID_NONE) begin
                if (data_byte inside {imu_fp_pkg::ID_SKIP, imu_fp_pkg::ID_ACCEL,
                                      imu_fp_pkg::ID_RATE, imu_fp_pkg::ID_MAGNET,
                                      imu_fp_pkg::ID_ATTITUDE}) begin
                  record_code_next   = data_byte;
                  record_offset_next = '0;
                  record_stage_next  = '0;
                end else begin
                  parse_stopped_next = imu_fp_pkg::RUN_UNKNOWN;
                end
              end else if (record_code == imu_fp_pkg::ID_SKIP) begin
                record_code_next = imu_fp_pkg::ID_NONE;
              end else begin
                record_stage_next[{record_offset, 3'b000} +: 8] = data_byte;
                record_offset_next = record_offset + 3'd1;
                if (record_offset_next >= imu_fp_pkg::REC_BYTES) begin
                  case (record_code)
                    imu_fp_pkg::ID_ACCEL:  kind = 2'd0;
                    imu_fp_pkg::ID_RATE:   kind = 2'd1;
                    imu_fp_pkg::ID_MAGNET: kind = 2'd2;
                    default:               kind = 2'd3;
                  endcase
                  if (kind == 2'd3) begin
                    hold_next[3][0] = imu_fp_pkg::angle_conv(record_stage_next[15:0]);
                    hold_next[3][1] = imu_fp_pkg::angle_conv(record_stage_next[31:16]);
                    hold_next[3][2] = imu_fp_pkg::YAW_BASE
                                      - {record_stage_next[47], record_stage_next[47:32]};
                  end else begin
                    hold_next[kind][0] = {record_stage_next[15], record_stage_next[15:0]};
                    hold_next[kind][1] = {record_stage_next[31], record_stage_next[31:16]};
                    hold_next[kind][2] = {record_stage_next[47], record_stage_next[47:32]};
                  end
                  seen_mask_next = seen_mask | (4'b0001 << kind);
                  if (seen_mask_next == imu_fp_pkg::ALL_SEEN)
                    parse_stopped_next = imu_fp_pkg::RUN_ALLSEEN;
                  record_code_next   = imu_fp_pkg::ID_NONE;
                  record_offset_next = '0;
                  record_stage_next  = '0;
                end
              end
            end
          end
          default: ;
        endcase
      end

      if (active && burst_end) begin
        res_valid = 1'b1;
        res.hold  = hold_next;
        if (phase_next != imu_fp_pkg::PH_DONE) begin
          res.status = imu_fp_pkg::ST_NO_FRAME;
        end else if (crc_accum_next != crc_received_next) begin
          res.status = imu_fp_pkg::ST_CRC_BAD;
        end else begin
          res.mask = seen_mask_next;
          if (parse_stopped_next == imu_fp_pkg::RUN_UNKNOWN)
            res.status = imu_fp_pkg::ST_UNKNOWN_ID;
          else if (parse_stopped_next == imu_fp_pkg::RUN_ALLSEEN)
            res.status = imu_fp_pkg::ST_OK;
          else
            res.status = imu_fp_pkg::ST_INCOMPLETE;
        end
        // close the frame, keep the holds
        phase_next          = imu_fp_pkg::PH_IDLE;
        byte_counter_next   = '0;
        payload_length_next = '0;
        crc_accum_next      = '0;
        crc_received_next   = '0;
        record_stage_next   = '0;
        record_code_next    = imu_fp_pkg::ID_NONE;
        record_offset_next  = '0;
        seen_mask_next      = '0;
        parse_stopped_next  = imu_fp_pkg::RUN_PARSING;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= imu_fp_pkg::PH_IDLE;
      byte_counter   <= '0;
      payload_length <= '0;
      crc_accum      <= '0;
      crc_received   <= '0;
      record_stage   <= '0;
      record_code    <= imu_fp_pkg::ID_NONE;
      record_offset  <= '0;
      seen_mask      <= '0;
      parse_stopped  <= imu_fp_pkg::RUN_PARSING;
      hold           <= '0;
    end else begin
      phase          <= phase_next;
      byte_counter   <= byte_counter_next;
      payload_length <= payload_length_next;
      crc_accum      <= crc_accum_next;
      crc_received   <= crc_received_next;
      record_stage   <= record_stage_next;
      record_code    <= record_code_next;
      record_offset  <= record_offset_next;
      seen_mask      <= seen_mask_next;
      parse_stopped  <= parse_stopped_next;
      hold           <= hold_next;
    end
  end

endmodule

// ----- rtl/imu_fp_emit.sv -----
`timescale 1ns / 1ps
module imu_fp_emit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load,
  input  imu_fp_pkg::frame_result_t  res,
  output logic                       free,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [63:0]                m_tdata,
  output logic                       m_tlast
);

  logic busy;
  logic [3:0] mask;
  logic [2:0] status;
  logic [3:0][2:0][16:0] hold;
  logic [1:0] kind;
  logic [2:0] item_kind;
  logic [16:0] vx, vy, vz;
  logic [2:0] item_status;
  logic done;

  always_comb begin
    kind = 2'd0;
    for (int k = 3; k >= 0; k--) begin
      if (mask[k]) kind = 2'(k);
    end
    if (mask != 4'd0) begin
      item_kind   = {1'b0, kind};
      vx          = hold[kind][0];
      vy          = hold[kind][1];
      vz          = hold[kind][2];
      item_status = imu_fp_pkg::ST_OK;
    end else begin
      item_kind   = imu_fp_pkg::KIND_STATUS;
      vx          = '0;
      vy          = '0;
      vz          = '0;
      item_status = status;
    end
  end

  assign m_tvalid = busy;
  assign m_tlast  = (mask == 4'd0);
  assign m_tdata  = {7'd0, item_status, vz, vy, vx, item_kind};
  assign done     = busy && m_tready && (mask == 4'd0);
  assign free     = !busy || done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      mask <= '0;
    end else if (load && free) begin
      busy <= 1'b1;
      mask <= res.mask;
    end else if (busy && m_tready) begin
      // drop the record just sent, or finish on the status transfer
      if (mask == 4'd0) busy <= 1'b0;
      else mask <= mask & ~(4'b0001 << kind);
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      status <= res.status;
      hold   <= res.hold;
    end
  end

  a_rst_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");
  a_rec_not_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && item_kind != imu_fp_pkg::KIND_STATUS) |-> !m_tlast)
    else $error("record marked last");
  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    (done && !load) |=> !m_tvalid)
    else $error("valid after final transfer");
  a_rec_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (item_status == imu_fp_pkg::ST_OK))
    else $error("record with nonzero status");

endmodule

// ----- rtl/imu_frame_parser.sv -----
`timescale 1ns / 1ps
// Frame parser for an inertial sensor byte stream. Takes one byte per cycle;
// a burst opens on tuser and closes on tlast. Each burst gets, at its
// closing byte, the records completed in the frame (whole frame with good
// CRC only, kind order) and then one status transfer with tlast set.
// A closing byte is taken only once the previous frame's results have all
// left, so a burst end waits while up to five result items still go out; all
// other bytes go through at one per cycle. The result register set is loaded
// by the closing byte's transfer and offers the first result in the next cycle.
module imu_frame_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,  // [7:0] data_byte
  input  logic        s_tuser,  // [0] burst_start
  input  logic        s_tlast,  // burst_end
  output logic        m_tvalid,
  input  logic        m_tready,
  // [2:0] record_kind, [19:3] value_x, [36:20] value_y, [53:37] value_z,
  // [56:54] frame_status, [63:57] zero
  output logic [63:0] m_tdata,
  output logic        m_tlast   // last
);

  logic free;
  logic res_valid;
  imu_fp_pkg::frame_result_t res;

  // hold only a closing byte while results are still going out
  assign s_tready = free || !s_tlast;

  imu_fp_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .take        (s_tvalid && s_tready),
    .data_byte   (s_tdata),
    .burst_start (s_tuser),
    .burst_end   (s_tlast),
    .res_valid   (res_valid),
    .res         (res)
  );

  imu_fp_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .load     (res_valid),
    .res      (res),
    .free     (free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// ----- sim/imu_frame_parser_tb.sv -----
`timescale 1ns / 1ps
module imu_frame_parser_tb;

  typedef struct {
    logic [2:0]  kind;
    logic [16:0] vx;
    logic [16:0] vy;
    logic [16:0] vz;
    logic [2:0]  status;
    logic        last;
  } imu_result_t;

  class frame_scoreboard;
    imu_result_t pending[$];
    int errors;
    imu_fp_pkg::phase_t phase;
    logic [15:0] count, plen, crc, crc_rx;
    logic [47:0] stage;
    logic [7:0]  code;
    int          offset;
    logic [3:0]  seen;
    logic [1:0]  stopped;
    int          hold[4][3];

    function new();
      errors = 0;
      foreach (hold[k, j]) hold[k][j] = 0;
      clear();
    endfunction

    function void clear();
      phase = imu_fp_pkg::PH_IDLE; count = 0; plen = 0; crc = 0; crc_rx = 0;
      stage = 0; code = imu_fp_pkg::ID_NONE; offset = 0; seen = 0;
      stopped = imu_fp_pkg::RUN_PARSING;
    endfunction

    function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      r = c ^ {b, 8'h00};
      repeat (8) r = r[15] ? ((r << 1) ^ imu_fp_pkg::CRC_POLY) : (r << 1);
      return r;
    endfunction

    function void commit();
      int a, b, c, k;
      a = $signed(stage[15:0]);
      b = $signed(stage[31:16]);
      c = $signed(stage[47:32]);
      case (code)
        imu_fp_pkg::ID_ACCEL:  k = 0;
        imu_fp_pkg::ID_RATE:   k = 1;
        imu_fp_pkg::ID_MAGNET: k = 2;
        default: begin
          k = 3; a = a / 10 + 1800; b = b / 10 + 1800; c = 3600 - c;
        end
      endcase
      hold[k][0] = a; hold[k][1] = b; hold[k][2] = c;
      seen[k] = 1'b1;
      if (seen == imu_fp_pkg::ALL_SEEN) stopped = imu_fp_pkg::RUN_ALLSEEN;
    endfunction

    function void decode(logic [7:0] b);
      if (stopped != imu_fp_pkg::RUN_PARSING) return;
      if (code == imu_fp_pkg::ID_NONE) begin
        if (b == imu_fp_pkg::ID_SKIP || b == imu_fp_pkg::ID_ACCEL ||
            b == imu_fp_pkg::ID_RATE || b == imu_fp_pkg::ID_MAGNET ||
            b == imu_fp_pkg::ID_ATTITUDE) begin
          code = b; offset = 0; stage = 0;
        end else stopped = imu_fp_pkg::RUN_UNKNOWN;
        return;
      end
      if (code == imu_fp_pkg::ID_SKIP) begin
        code = imu_fp_pkg::ID_NONE;
        return;
      end
      stage[8*offset +: 8] = b;
      offset++;
      if (offset >= 6) begin
        commit();
        code = imu_fp_pkg::ID_NONE; offset = 0; stage = 0;
      end
    endfunction

    function void push(logic [2:0] k, int x, int y, int z, logic [2:0] st, logic l);
      imu_result_t r;
      r.kind = k; r.vx = x[16:0]; r.vy = y[16:0]; r.vz = z[16:0];
      r.status = st; r.last = l;
      pending.push_back(r);
    endfunction

    function void note_byte(logic [7:0] b, logic start, logic stop);
      logic [2:0] st;
      if (start) begin
        clear();
        if (b == imu_fp_pkg::SYNC_A) begin
          crc = crc_step(16'h0, b); phase = imu_fp_pkg::PH_B1;
        end else phase = imu_fp_pkg::PH_BAD;
      end else if (phase == imu_fp_pkg::PH_IDLE) begin
        return;
      end else begin
        case (phase)
          imu_fp_pkg::PH_B1:
            if (b == imu_fp_pkg::SYNC_B) begin
              crc = crc_step(crc, b); phase = imu_fp_pkg::PH_LENL;
            end else if (b == imu_fp_pkg::SYNC_A) phase = imu_fp_pkg::PH_B2;
            else phase = imu_fp_pkg::PH_BAD;
          imu_fp_pkg::PH_B2:
            if (b == imu_fp_pkg::SYNC_B) begin
              crc = crc_step(crc, b); phase = imu_fp_pkg::PH_LENL;
            end else phase = imu_fp_pkg::PH_BAD;
          imu_fp_pkg::PH_LENL: begin
            crc = crc_step(crc, b); plen = {8'h00, b}; phase = imu_fp_pkg::PH_LENH;
          end
          imu_fp_pkg::PH_LENH: begin
            crc = crc_step(crc, b); plen[15:8] = b; phase = imu_fp_pkg::PH_CRCL;
          end
          imu_fp_pkg::PH_CRCL: begin
            crc_rx = {8'h00, b}; phase = imu_fp_pkg::PH_CRCH;
          end
          imu_fp_pkg::PH_CRCH: begin
            crc_rx[15:8] = b;
            phase = (plen == 0) ? imu_fp_pkg::PH_DONE : imu_fp_pkg::PH_PAY;
          end
          imu_fp_pkg::PH_PAY: begin
            crc = crc_step(crc, b);
            decode(b);
            count++;
            if (count >= plen) phase = imu_fp_pkg::PH_DONE;
          end
          default: ;
        endcase
      end
      if (!stop) return;
      if (phase != imu_fp_pkg::PH_DONE) st = imu_fp_pkg::ST_NO_FRAME;
      else if (crc != crc_rx) st = imu_fp_pkg::ST_CRC_BAD;
      else begin
        for (int k = 0; k < 4; k++)
          if (seen[k]) push(3'(k), hold[k][0], hold[k][1], hold[k][2],
                            imu_fp_pkg::ST_OK, 1'b0);
        if (stopped == imu_fp_pkg::RUN_UNKNOWN) st = imu_fp_pkg::ST_UNKNOWN_ID;
        else if (stopped == imu_fp_pkg::RUN_ALLSEEN) st = imu_fp_pkg::ST_OK;
        else st = imu_fp_pkg::ST_INCOMPLETE;
      end
      push(imu_fp_pkg::KIND_STATUS, 0, 0, 0, st, 1'b1);
      clear();
    endfunction

    function void check(logic [63:0] d, logic l);
      imu_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result %h", d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[2:0] !== e.kind) begin
        $error("record_kind exp %0d got %0d", e.kind, d[2:0]); errors++;
      end
      if (d[19:3] !== e.vx) begin
        $error("value_x exp %h got %h", e.vx, d[19:3]); errors++;
      end
      if (d[36:20] !== e.vy) begin
        $error("value_y exp %h got %h", e.vy, d[36:20]); errors++;
      end
      if (d[53:37] !== e.vz) begin
        $error("value_z exp %h got %h", e.vz, d[53:37]); errors++;
      end
      if (d[56:54] !== e.status) begin
        $error("frame_status exp %0d got %0d", e.status, d[56:54]); errors++;
      end
      if (l !== e.last) begin
        $error("last exp %0d got %0d", e.last, l); errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tuser = 1'b0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic        m_tlast;

  frame_scoreboard board = new();
  bit calm = 1'b0;
  bit hold_off = 1'b0;
  int n_bytes = 0;

  imu_frame_parser DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check(m_tdata, m_tlast);
    m_tready <= !rst && !hold_off && (calm || $urandom_range(99) >= 11);
  end

  logic [7:0] burst[$];

  task automatic send_byte(logic [7:0] b, logic start, logic stop);
    int gap;
    gap = 0;
    while (!calm && $urandom_range(99) < 11) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1; s_tdata <= b; s_tuser <= start; s_tlast <= stop;
    do @(posedge clk); while (!s_tready);
    board.note_byte(b, start, stop);
    n_bytes++;
  endtask

  task automatic send_burst();
    foreach (burst[i]) send_byte(burst[i], i == 0, i == burst.size() - 1);
  endtask

  // build a frame from a payload; optionally bad CRC, long sync, tail bytes
  task automatic build_frame(logic [7:0] pay[$], bit long_sync, bit bad_crc, int tail);
    logic [15:0] c, n;
    n = 16'(pay.size());
    c = board.crc_step(board.crc_step(16'h0, imu_fp_pkg::SYNC_A), imu_fp_pkg::SYNC_B);
    c = board.crc_step(board.crc_step(c, n[7:0]), n[15:8]);
    foreach (pay[i]) c = board.crc_step(c, pay[i]);
    if (bad_crc) c ^= 16'h1 << $urandom_range(15);
    burst.delete();
    if (long_sync) burst.push_back(imu_fp_pkg::SYNC_A);
    burst.push_back(imu_fp_pkg::SYNC_A); burst.push_back(imu_fp_pkg::SYNC_B);
    burst.push_back(n[7:0]); burst.push_back(n[15:8]);
    burst.push_back(c[7:0]); burst.push_back(c[15:8]);
    foreach (pay[i]) burst.push_back(pay[i]);
    repeat (tail) burst.push_back(8'($urandom_range(255)));
  endtask

  function automatic void add_record(ref logic [7:0] pay[$], input logic [7:0] id,
                                     input int nbytes);
    pay.push_back(id);
    repeat (nbytes) pay.push_back(8'($urandom_range(255)));
  endfunction

  task automatic random_frame();
    logic [7:0] pay[$];
    logic [7:0] ids[5];
    int mode, nrec;
    ids = '{imu_fp_pkg::ID_SKIP, imu_fp_pkg::ID_ACCEL, imu_fp_pkg::ID_RATE,
            imu_fp_pkg::ID_MAGNET, imu_fp_pkg::ID_ATTITUDE};
    nrec = $urandom_range(5);
    for (int r = 0; r < nrec; r++) begin
      logic [7:0] id;
      id = ids[$urandom_range(4)];
      add_record(pay, id, id == imu_fp_pkg::ID_SKIP ? 1 : 6);
    end
    mode = $urandom_range(99);
    if (mode < 8) add_record(pay, 8'($urandom_range(255)), 2);
    else if (mode < 16 && pay.size() != 0) void'(pay.pop_back());
    build_frame(pay, $urandom_range(3) == 0, $urandom_range(9) == 0,
                $urandom_range(5) == 0 ? $urandom_range(3) : 0);
    mode = $urandom_range(99);
    if (mode < 5) burst[$urandom_range(1)] = 8'($urandom_range(255));
    else if (mode < 9 && burst.size() > 7) burst = burst[0:$urandom_range(burst.size() - 2)];
    send_burst();
    if ($urandom_range(9) == 0)
      send_byte(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
  endtask

  initial begin
    logic [7:0] pay[$];
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // full frame with extreme values
    pay = '{imu_fp_pkg::ID_ACCEL, 8'h00, 8'h80, 8'hFF, 8'h7F, 8'h00, 8'h00,
            imu_fp_pkg::ID_RATE, 8'hFF, 8'hFF, 8'h01, 8'h00, 8'h55, 8'hAA,
            imu_fp_pkg::ID_SKIP, 8'h33,
            imu_fp_pkg::ID_MAGNET, 8'hFF, 8'h7F, 8'h00, 8'h80, 8'h12, 8'h34,
            imu_fp_pkg::ID_ATTITUDE, 8'h00, 8'h80, 8'hFF, 8'h7F, 8'hF7, 8'hFF,
            8'hEE, 8'hFF};
    build_frame(pay, 1'b0, 1'b0, 2); send_burst();
    pay = '{imu_fp_pkg::ID_ATTITUDE, 8'hF6, 8'hFF, 8'h09, 8'h00, 8'h01, 8'h80};
    build_frame(pay, 1'b1, 1'b0, 0); send_burst();
    pay = '{imu_fp_pkg::ID_ACCEL, 8'h01, 8'h02, 8'h03};
    build_frame(pay, 1'b0, 1'b0, 0); send_burst();   // record cut off
    pay = '{imu_fp_pkg::ID_ACCEL, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06,
            imu_fp_pkg::ID_SKIP};
    build_frame(pay, 1'b0, 1'b0, 0); send_burst();   // skip cut off
    pay = '{imu_fp_pkg::ID_RATE, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66,
            8'h42, 8'h00};
    build_frame(pay, 1'b0, 1'b0, 0); send_burst();   // unknown id
    build_frame(pay, 1'b0, 1'b1, 0); send_burst();   // bad crc
    pay.delete();
    build_frame(pay, 1'b0, 1'b0, 0); send_burst();   // empty payload
    burst = '{8'h5A, 8'h5A, 8'h5A, 8'hA5}; send_burst();  // header mismatch
    burst = '{8'hA5, 8'h00}; send_burst();
    send_byte(8'hFF, 1'b1, 1'b1);
    send_byte(8'h5A, 1'b0, 1'b1);                    // outside a burst
    send_byte(8'h5A, 1'b1, 1'b0);                    // abandoned by new start
    send_byte(8'hA5, 1'b0, 1'b0);
    burst = '{8'h5A, 8'hA5, 8'h02}; send_burst();    // ends inside header

    while (n_bytes < 310) begin
      if (n_bytes > 150 && n_bytes < 230) calm = 1'b1;
      else calm = 1'b0;
      random_frame();
    end
    s_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.errors == 0) $display("imu_frame_parser test passed");
    else $display("imu_frame_parser test failed");
    $finish;
  end

  // long receiver hold-off while frames keep coming
  initial begin
    wait (n_bytes > 200);
    hold_off = 1'b1;
    repeat (300) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    #2000000;
    $display("imu_frame_parser test failed");
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/imu_fp_pkg.sv
rtl/imu_fp_parse.sv
rtl/imu_fp_emit.sv
rtl/imu_frame_parser.sv
sim/imu_frame_parser_tb.sv
